/* rtl/third_chance_page_replacement_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the page replacement block
// Clock and reset names clk and arst_n are taken from the enclosing module.
// ---------------------------------------------------------------------------
`ifndef THIRD_CHANCE_PAGE_REPLACEMENT_DEFINES_SVH
`define THIRD_CHANCE_PAGE_REPLACEMENT_DEFINES_SVH

`ifndef ASSERT_OFF
`define TCPR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define TCPR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TCPR_ASSERT(lbl, prop, msg)
`define TCPR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/tcpr_pkg.sv */
// ---------------------------------------------------------------------------
// tcpr_pkg
// Types, constants and the microcode program of the page replacement block.
// ---------------------------------------------------------------------------
`default_nettype none

package tcpr_pkg;

	localparam int FRAMES    = 16;
	localparam int SLOT_W    = $clog2(FRAMES);
	localparam int CNT_W     = $clog2(FRAMES + 1);
	localparam int ADDR_W    = 32;
	localparam int PAGE_LSB  = 12;
	localparam int PAGE_W    = ADDR_W - PAGE_LSB;
	localparam int FAULT_W   = 32;
	localparam int CFG_W     = 5;
	localparam int POS_W     = 4;
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

	// Program steps of the sequencer.
	typedef enum logic [2:0] {
		ST_IDLE     = 3'd0,
		ST_SCAN_RD  = 3'd1,
		ST_SCAN_CMP = 3'd2,
		ST_DONE     = 3'd3,
		ST_FAULT    = 3'd4,
		ST_EV_RD    = 3'd5,
		ST_EV_TEST  = 3'd6,
		ST_APPEND   = 3'd7
	} step_t;

	// Jump conditions: when true the sequencer goes to the target step,
	// otherwise it falls through to the next one.
	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_START,
		COND_SCAN_END,
		COND_NO_MATCH,
		COND_NOT_FULL,
		COND_NO_VICTIM
	} cond_t;

	typedef struct packed {
		cond_t cond;
		step_t target;
		logic  ld_item;
		logic  rd_scan;
		logic  scan_cmp;
		logic  strobe;
		logic  fault;
		logic  rd_head;
		logic  ev_test;
		logic  append;
	} ctrl_t;

	localparam ctrl_t CTRL_NOP = '{cond: COND_NEVER, target: ST_IDLE, default: 1'b0};

	function automatic ctrl_t ucode_rom(input step_t step);
		ctrl_t w;
		w = CTRL_NOP;
		case (step)
			ST_IDLE: begin
				w.cond = COND_NO_START;  w.target = ST_IDLE;    w.ld_item = 1'b1;
			end
			ST_SCAN_RD: begin
				w.cond = COND_SCAN_END;  w.target = ST_FAULT;   w.rd_scan = 1'b1;
			end
			ST_SCAN_CMP: begin
				w.cond = COND_NO_MATCH;  w.target = ST_SCAN_RD; w.scan_cmp = 1'b1;
			end
			ST_DONE: begin
				w.cond = COND_ALWAYS;    w.target = ST_IDLE;    w.strobe = 1'b1;
			end
			ST_FAULT: begin
				w.cond = COND_NOT_FULL;  w.target = ST_APPEND;  w.fault = 1'b1;
			end
			ST_EV_RD: begin
				w.cond = COND_NEVER;     w.target = ST_IDLE;    w.rd_head = 1'b1;
			end
			ST_EV_TEST: begin
				w.cond = COND_NO_VICTIM; w.target = ST_EV_RD;   w.ev_test = 1'b1;
			end
			ST_APPEND: begin
				w.cond = COND_ALWAYS;    w.target = ST_DONE;    w.append = 1'b1;
			end
			default: w = CTRL_NOP;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

/* rtl/third_chance_page_replacement.sv */
// ---------------------------------------------------------------------------
// third_chance_page_replacement
// Enhanced second chance page replacement over a FIFO of resident pages.
// ---------------------------------------------------------------------------
// A transaction starts when start is high while busy is low; command and
// address are sampled at that edge and busy stays high until the result is
// shown. The result is on hit, fault_total, evicted_valid, evicted_page and
// queue_position for exactly one cycle with done high; the receiver cannot
// stall, so the result must be taken in that cycle.
// A short microcode program steps a single datapath: the resident queue is
// scanned one entry at a time (memory read, then compare), and on a fault
// with a full queue the head is rotated (read, then test) until a victim
// leaves; the rotations number at most twice the occupancy. The next
// transaction can be accepted in the cycle after done.
// The frames_in_use register is written on cfg_valid (cfg_ready is always
// high); write it only while no transaction is in flight, as the block
// itself does not enforce this. Reset empties the queue, clears the fault
// count and sets frames_in_use to 16; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

`include "third_chance_page_replacement_defines.svh"

module third_chance_page_replacement (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            command,
	input  logic [tcpr_pkg::ADDR_W-1:0]     address,
	output logic                            done,
	output logic                            hit,
	output logic [tcpr_pkg::FAULT_W-1:0]    fault_total,
	output logic                            evicted_valid,
	output logic [tcpr_pkg::PAGE_W-1:0]     evicted_page,
	output logic [tcpr_pkg::POS_W-1:0]      queue_position,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tcpr_pkg::CFG_W-1:0]      cfg_data
);

	import tcpr_pkg::*;

	step_t upc_q, upc_d;
	ctrl_t ctrl;
	logic  take_jump;

	logic [CFG_W-1:0]   cfg_q;
	logic [SLOT_W-1:0]  head_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   idx_q;
	logic [FAULT_W-1:0] fault_q;
	logic [PAGE_W-1:0]  page_q;
	logic               write_q;
	logic               hit_q;
	logic               ev_q;
	logic [PAGE_W-1:0]  evp_q;
	logic [POS_W-1:0]   pos_q;
	logic [FRAMES-1:0]  ref_q;
	logic [FRAMES-1:0]  mod_q;

	logic [PAGE_W-1:0]  page_mem [FRAMES];
	logic [PAGE_W-1:0]  rdata_q;

	logic [CNT_W-1:0]   cap;
	logic [SLOT_W-1:0]  scan_slot;
	logic [SLOT_W-1:0]  tail_slot;
	logic [SLOT_W-1:0]  head_next;
	logic               scan_end;
	logic               match;
	logic               full;
	logic               victim;
	logic               mem_we;
	logic [SLOT_W-1:0]  mem_ra;
	logic [PAGE_W-1:0]  mem_wd;

	// Datapath status.
	always_comb begin
		if (cfg_q == '0) begin
			cap = CNT_W'(1);
		end else if (CNT_W'(cfg_q) > CNT_W'(FRAMES)) begin
			cap = CNT_W'(FRAMES);
		end else begin
			cap = CNT_W'(cfg_q);
		end
	end

	assign scan_slot = head_q + idx_q[SLOT_W-1:0];
	assign tail_slot = head_q + count_q[SLOT_W-1:0];
	assign head_next = head_q + SLOT_W'(1);
	assign scan_end  = (idx_q == count_q);
	assign match     = (rdata_q == page_q);
	assign full      = (count_q >= cap) && (count_q != '0);
	assign victim    = !ref_q[head_q] && !mod_q[head_q];

	// Sequencer.
	always_comb begin
		ctrl = ucode_rom(upc_q);
		case (ctrl.cond)
			COND_NEVER:     take_jump = 1'b0;
			COND_ALWAYS:    take_jump = 1'b1;
			COND_NO_START:  take_jump = !start;
			COND_SCAN_END:  take_jump = scan_end;
			COND_NO_MATCH:  take_jump = !match;
			COND_NOT_FULL:  take_jump = !full;
			COND_NO_VICTIM: take_jump = !victim;
			default:        take_jump = 1'b0;
		endcase
		upc_d = take_jump ? ctrl.target : step_t'(upc_q + 3'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= ST_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

	assign busy      = (upc_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// Page memory: one write and one registered read per cycle.
	assign mem_we = (ctrl.ev_test && !victim) || ctrl.append;
	assign mem_ra = ctrl.rd_head ? head_q : scan_slot;
	assign mem_wd = ctrl.append ? page_q : rdata_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			page_mem[tail_slot] <= mem_wd;
		end
		rdata_q <= page_mem[mem_ra];
	end

	// Item and result registers.
	always_ff @(posedge clk) begin
		if (ctrl.ld_item) begin
			page_q  <= address[ADDR_W-1:PAGE_LSB];
			write_q <= command;
			hit_q   <= 1'b0;
			ev_q    <= 1'b0;
			evp_q   <= '0;
		end
		if (ctrl.scan_cmp && match) begin
			hit_q <= 1'b1;
			pos_q <= POS_W'(idx_q);
		end
		if (ctrl.ev_test && victim) begin
			ev_q  <= 1'b1;
			evp_q <= rdata_q;
		end
		if (ctrl.append) begin
			pos_q <= POS_W'(count_q);
		end
	end

	// Queue state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q   <= CFG_RESET;
			head_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
			fault_q <= '0;
			ref_q   <= '0;
			mod_q   <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cfg_q <= cfg_data;
			end
			if (ctrl.ld_item) begin
				idx_q <= '0;
			end
			if (ctrl.scan_cmp) begin
				if (match) begin
					ref_q[scan_slot] <= 1'b1;
					if (write_q) begin
						mod_q[scan_slot] <= 1'b1;
					end
				end else begin
					idx_q <= idx_q + CNT_W'(1);
				end
			end
			if (ctrl.fault && (fault_q != '1)) begin
				fault_q <= fault_q + FAULT_W'(1);
			end
			if (ctrl.ev_test) begin
				head_q <= head_next;
				if (victim) begin
					count_q <= count_q - CNT_W'(1);
				end else begin
					// The head page moves to the tail with one chance used up.
					ref_q[tail_slot] <= 1'b0;
					mod_q[tail_slot] <= ref_q[head_q] && mod_q[head_q];
				end
			end
			if (ctrl.append) begin
				// Only the appended page has its referenced bit set; all others are cleared.
				ref_q            <= FRAMES'(1) << tail_slot;
				mod_q[tail_slot] <= write_q;
				count_q          <= count_q + CNT_W'(1);
			end
		end
	end

	assign done           = ctrl.strobe;
	assign hit            = hit_q;
	assign fault_total    = fault_q;
	assign evicted_valid  = ev_q;
	assign evicted_page   = evp_q;
	assign queue_position = pos_q;

	`TCPR_ASSERT(a_count_range, count_q <= CNT_W'(FRAMES), "resident count above frame count")
	`TCPR_ASSERT(a_evict_on_fault, !(done && evicted_valid && hit), "eviction reported on a hit")
	`TCPR_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
	`TCPR_ASSERT_NEXT(a_done_idle, done, !busy, "sequencer not idle after result")
	`TCPR_ASSERT(a_append_room, !(ctrl.append && (count_q >= CNT_W'(FRAMES))), "append into a full queue")

endmodule

`default_nettype wire
